// ----- src/infix_integer_expression_evaluator_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the infix integer expression evaluator.
// Each macro expects signals named clk and rst_n in the using module.
// ----------------------------------------------------------------------------
`ifndef INFIX_INTEGER_EXPRESSION_EVALUATOR_MACROS_SVH
`define INFIX_INTEGER_EXPRESSION_EVALUATOR_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define IIEE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define IIEE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/iiee_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iiee_pkg
// Types and character codes for the infix integer expression evaluator.
// ----------------------------------------------------------------------------
package iiee_pkg;

  // Characters the parser recognizes.
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_MUL   = 8'h2A;
  localparam logic [7:0] CH_ADD   = 8'h2B;
  localparam logic [7:0] CH_SUB   = 8'h2D;
  localparam logic [7:0] CH_DIV   = 8'h2F;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // Parse position within the expression.
  typedef enum logic [2:0] {
    PH_FIRST   = 3'd0,
    PH_OPERAND = 3'd1,
    PH_NEG     = 3'd2,
    PH_DIGITS  = 3'd3,
    PH_OPER    = 3'd4,
    PH_IGNORE  = 3'd5
  } phase_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_SYNTAX = 2'd2,
    ST_DIV0   = 2'd3
  } status_t;

  // Pending multiplicative operator.
  typedef enum logic [1:0] {
    OP_NONE = 2'd0,
    OP_MUL  = 2'd1,
    OP_DIV  = 2'd2
  } term_op_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE = 3'd0,
    S_PROC = 3'd1,
    S_MUL  = 3'd2,
    S_DIV  = 3'd3,
    S_DFIX = 3'd4
  } state_t;

endpackage

// ----- src/infix_integer_expression_evaluator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// infix_integer_expression_evaluator
// Evaluates an infix integer expression fed one character per beat.
// ----------------------------------------------------------------------------
// Usage: the input channel (in_valid, in_stall, in_ch) carries one ASCII
// character per beat. Byte 0 closes the expression, and exactly one result
// beat (out_value, out_status) follows on the output channel; other
// characters give no result. Multiplication and division bind tighter than
// addition and subtraction, each operand may carry one unary minus, spaces
// are skipped and arithmetic wraps at VALUE_WIDTH bits.
// Timing: a character is taken in one cycle and handled in the next. The
// character that ends a literal also folds it into the current term: directly
// without a pending operator, through the S_MUL steps after '*' and through
// the S_DIV steps and S_DFIX after '/'. The one shift-and-add/subtract unit
// steps one bit per cycle. The end byte's result beat is registered when the
// byte is handled (after the fold above), once the output register is free.
// A waiting result sits in an output register, and further characters are
// still taken; only the next end byte waits for the receiver to drain it.
// Reset (synchronous, active low) clears the parse state and drops any
// pending result.
// ----------------------------------------------------------------------------
module infix_integer_expression_evaluator #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  // Character input channel.
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_ch,
  // Result output channel.
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_value,
  output logic [1:0]         out_status
);

  `include "infix_integer_expression_evaluator_macros.svh"

  localparam int W  = VALUE_WIDTH;
  localparam int CW = $clog2(VALUE_WIDTH);

  // Sequencer and parse state.
  iiee_pkg::state_t   state_r,   state_nxt;
  iiee_pkg::phase_t   phase_r,   phase_nxt;
  iiee_pkg::status_t  err_r,     err_nxt;
  iiee_pkg::term_op_t top_r,     top_nxt;

  // Expression accumulators.
  logic [W-1:0] sum_r,  sum_nxt;
  logic         sub_r,  sub_nxt;
  logic [W-1:0] term_r, term_nxt;
  logic [W-1:0] num_r,  num_nxt;
  logic         neg_r,  neg_nxt;

  // Captured character.
  logic [7:0] ch_r, ch_nxt;

  // Iterative unit operands. In multiply, opa holds the multiplicand, opb the
  // multiplier and acc the partial product. In divide, opa holds the divisor,
  // opb the dividend shifting out as quotient bits shift in, acc the remainder.
  logic [W-1:0]  opa_r, opa_nxt;
  logic [W-1:0]  opb_r, opb_nxt;
  logic [W-1:0]  acc_r, acc_nxt;
  logic          qneg_r, qneg_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  // Output register.
  logic                 out_valid_r, out_valid_nxt;
  logic [31:0]          out_value_r, out_value_nxt;
  iiee_pkg::status_t    out_status_r, out_status_nxt;

  // Shared adder/subtractor.
  logic [W:0]   alu_a, alu_b;
  logic         alu_sub;
  logic [W+1:0] alu_res;

  // Helper values.
  logic [W-1:0] total;
  logic [W-1:0] opnd;
  logic [W-1:0] opnd_mag;
  logic [W-1:0] term_mag;
  logic         is_digit;
  logic         out_free;
  logic         div_ge;

  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    unique case (state_r)
      iiee_pkg::S_MUL: begin
        alu_a = {1'b0, acc_r[W-2:0], 1'b0};
        alu_b = opb_r[W-1] ? {1'b0, opa_r} : '0;
      end
      iiee_pkg::S_DIV: begin
        alu_a   = {acc_r, opb_r[W-1]};
        alu_b   = {1'b0, opa_r};
        alu_sub = 1'b1;
      end
      default: begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
      end
    endcase
  end

  // For a subtraction the top bit is the carry out, high when a >= b.
  assign alu_res = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)}
                 + (W+2)'(alu_sub);
  assign div_ge  = alu_res[W+1];

  assign total    = sub_r ? (sum_r - term_r) : (sum_r + term_r);
  assign opnd     = neg_r ? (W'(0) - num_r) : num_r;
  assign opnd_mag = opnd[W-1] ? (W'(0) - opnd) : opnd;
  assign term_mag = term_r[W-1] ? (W'(0) - term_r) : term_r;
  assign is_digit = (ch_r >= iiee_pkg::CH_ZERO) && (ch_r <= iiee_pkg::CH_NINE);
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    logic fold_go;
    logic fold_done;
    logic clear_all;

    fold_go   = 1'b0;
    fold_done = 1'b0;
    clear_all = 1'b0;

    state_nxt      = state_r;
    phase_nxt      = phase_r;
    err_nxt        = err_r;
    top_nxt        = top_r;
    sum_nxt        = sum_r;
    sub_nxt        = sub_r;
    term_nxt       = term_r;
    num_nxt        = num_r;
    neg_nxt        = neg_r;
    ch_nxt         = ch_r;
    opa_nxt        = opa_r;
    opb_nxt        = opb_r;
    acc_nxt        = acc_r;
    qneg_nxt       = qneg_r;
    cnt_nxt        = cnt_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;

    unique case (state_r)
      iiee_pkg::S_IDLE: begin
        if (in_valid) begin
          ch_nxt    = in_ch;
          state_nxt = iiee_pkg::S_PROC;
        end
      end

      iiee_pkg::S_PROC: begin
        if (ch_r == iiee_pkg::CH_NUL) begin
          // A literal still open is folded first; this state then runs again.
          if (err_r == iiee_pkg::ST_OK && phase_r == iiee_pkg::PH_DIGITS) begin
            fold_go = 1'b1;
          end else if (out_free) begin
            out_valid_nxt = 1'b1;
            out_value_nxt = '0;
            if (err_r != iiee_pkg::ST_OK) begin
              out_status_nxt = err_r;
            end else if (phase_r == iiee_pkg::PH_FIRST) begin
              out_status_nxt = iiee_pkg::ST_EMPTY;
            end else if (phase_r == iiee_pkg::PH_OPERAND ||
                         phase_r == iiee_pkg::PH_NEG) begin
              out_status_nxt = iiee_pkg::ST_SYNTAX;
            end else begin
              out_status_nxt = iiee_pkg::ST_OK;
              out_value_nxt  = 32'(total);
            end
            clear_all = 1'b1;
            state_nxt = iiee_pkg::S_IDLE;
          end
        end else if (err_r != iiee_pkg::ST_OK || phase_r == iiee_pkg::PH_IGNORE) begin
          state_nxt = iiee_pkg::S_IDLE;
        end else if (phase_r == iiee_pkg::PH_DIGITS) begin
          if (is_digit) begin
            num_nxt   = (num_r << 3) + (num_r << 1) + W'(ch_r[3:0]);
            state_nxt = iiee_pkg::S_IDLE;
          end else begin
            fold_go = 1'b1;
          end
        end else if (phase_r == iiee_pkg::PH_OPER) begin
          state_nxt = iiee_pkg::S_IDLE;
          if (ch_r == iiee_pkg::CH_SPACE) begin
            state_nxt = iiee_pkg::S_IDLE;
          end else if (ch_r == iiee_pkg::CH_MUL || ch_r == iiee_pkg::CH_DIV) begin
            top_nxt   = (ch_r == iiee_pkg::CH_MUL) ? iiee_pkg::OP_MUL : iiee_pkg::OP_DIV;
            phase_nxt = iiee_pkg::PH_OPERAND;
          end else if (ch_r == iiee_pkg::CH_ADD || ch_r == iiee_pkg::CH_SUB) begin
            sum_nxt   = total;
            sub_nxt   = (ch_r == iiee_pkg::CH_SUB);
            term_nxt  = '0;
            top_nxt   = iiee_pkg::OP_NONE;
            phase_nxt = iiee_pkg::PH_OPERAND;
          end else if (is_digit) begin
            phase_nxt = iiee_pkg::PH_IGNORE;
          end else begin
            err_nxt = iiee_pkg::ST_SYNTAX;
          end
        end else begin
          // An operand is due.
          state_nxt = iiee_pkg::S_IDLE;
          if (ch_r == iiee_pkg::CH_SPACE) begin
            state_nxt = iiee_pkg::S_IDLE;
          end else if (is_digit) begin
            num_nxt   = W'(ch_r[3:0]);
            phase_nxt = iiee_pkg::PH_DIGITS;
          end else if (ch_r == iiee_pkg::CH_SUB && phase_r != iiee_pkg::PH_NEG) begin
            neg_nxt   = 1'b1;
            phase_nxt = iiee_pkg::PH_NEG;
          end else begin
            err_nxt = iiee_pkg::ST_SYNTAX;
          end
        end

        if (fold_go) begin
          case (top_r)
            iiee_pkg::OP_MUL: begin
              opa_nxt   = term_r;
              opb_nxt   = opnd;
              acc_nxt   = '0;
              cnt_nxt   = CW'(W - 1);
              state_nxt = iiee_pkg::S_MUL;
            end
            iiee_pkg::OP_DIV: begin
              if (opnd == '0) begin
                err_nxt   = iiee_pkg::ST_DIV0;
                fold_done = 1'b1;
              end else begin
                opa_nxt   = opnd_mag;
                opb_nxt   = term_mag;
                acc_nxt   = '0;
                qneg_nxt  = term_r[W-1] ^ opnd[W-1];
                cnt_nxt   = CW'(W - 1);
                state_nxt = iiee_pkg::S_DIV;
              end
            end
            default: begin
              term_nxt  = opnd;
              fold_done = 1'b1;
            end
          endcase
        end
      end

      iiee_pkg::S_MUL: begin
        acc_nxt = alu_res[W-1:0];
        opb_nxt = opb_r << 1;
        if (cnt_r == '0) begin
          term_nxt  = alu_res[W-1:0];
          fold_done = 1'b1;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end

      iiee_pkg::S_DIV: begin
        acc_nxt = div_ge ? alu_res[W-1:0] : {acc_r[W-2:0], opb_r[W-1]};
        opb_nxt = {opb_r[W-2:0], div_ge};
        if (cnt_r == '0) begin
          state_nxt = iiee_pkg::S_DFIX;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end

      iiee_pkg::S_DFIX: begin
        term_nxt  = qneg_r ? (W'(0) - opb_r) : opb_r;
        fold_done = 1'b1;
      end

      default: begin
        state_nxt = iiee_pkg::S_IDLE;
      end
    endcase

    // The literal is folded; the pending character is handled again.
    if (fold_done) begin
      num_nxt   = '0;
      neg_nxt   = 1'b0;
      top_nxt   = iiee_pkg::OP_NONE;
      phase_nxt = iiee_pkg::PH_OPER;
      state_nxt = iiee_pkg::S_PROC;
    end

    if (clear_all) begin
      sum_nxt   = '0;
      sub_nxt   = 1'b0;
      term_nxt  = '0;
      top_nxt   = iiee_pkg::OP_NONE;
      num_nxt   = '0;
      neg_nxt   = 1'b0;
      phase_nxt = iiee_pkg::PH_FIRST;
      err_nxt   = iiee_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= iiee_pkg::S_IDLE;
      phase_r     <= iiee_pkg::PH_FIRST;
      err_r       <= iiee_pkg::ST_OK;
      top_r       <= iiee_pkg::OP_NONE;
      sum_r       <= '0;
      sub_r       <= 1'b0;
      term_r      <= '0;
      num_r       <= '0;
      neg_r       <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      err_r       <= err_nxt;
      top_r       <= top_nxt;
      sum_r       <= sum_nxt;
      sub_r       <= sub_nxt;
      term_r      <= term_nxt;
      num_r       <= num_nxt;
      neg_r       <= neg_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ch_r         <= ch_nxt;
    opa_r        <= opa_nxt;
    opb_r        <= opb_nxt;
    acc_r        <= acc_nxt;
    qneg_r       <= qneg_nxt;
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
  end

  assign in_stall   = (state_r != iiee_pkg::S_IDLE);
  assign out_valid  = out_valid_r;
  assign out_value  = out_value_r;
  assign out_status = out_status_r;

  // A result that reports a problem never carries a value.
  `IIEE_ASSERT_NOW(a_err_value_zero,
    out_valid_r && out_status_r != iiee_pkg::ST_OK, out_value_r == 32'd0,
    "error result with nonzero value")

  // The iterative unit only runs while no error is latched.
  `IIEE_ASSERT_NOW(a_unit_no_err,
    state_r == iiee_pkg::S_MUL || state_r == iiee_pkg::S_DIV, err_r == iiee_pkg::ST_OK,
    "iterative unit running with an error latched")

  // A zero divisor is caught before the divider starts.
  `IIEE_ASSERT_NOW(a_div_nonzero,
    state_r == iiee_pkg::S_DIV, opa_r != '0,
    "divider running with a zero divisor")

  // A new result appears only after the end byte is handled.
  `IIEE_ASSERT_NOW(a_result_source,
    $rose(out_valid_r), $past(state_r) == iiee_pkg::S_PROC && $past(ch_r) == iiee_pkg::CH_NUL,
    "result raised outside end byte handling")

  // An accepted character is handled in the following cycle.
  `IIEE_ASSERT_NEXT(a_accept_proc,
    in_valid && !in_stall, state_r == iiee_pkg::S_PROC,
    "accepted character not handled next cycle")

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the infix integer expression evaluator. Characters
// go in one beat at a time; a model of the parser inside the bench predicts
// the single result beat that each end byte produces. Every result beat is
// checked against the oldest prediction. A short directed part covers the
// corner cases, and a long random part follows under four idle and stall mixes.
// ----------------------------------------------------------------------------
module tb;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [7:0]         in_ch = 8'h00;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [31:0] out_value;
  logic [1:0]         out_status;

  infix_integer_expression_evaluator u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_ch      (in_ch),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_value  (out_value),
    .out_status (out_status)
  );

  // 10 ns clock: rising edges at 5, 15, 25 ns and so on.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Percent chance, per cycle, that the sender idles or the receiver stalls.
  int idle_pct = 0;
  int stall_pct = 0;
  int chars_sent = 0;
  int fail_count = 0;

  // Results the evaluator still owes us, oldest first.
  logic [31:0]       due_values[$];
  iiee_pkg::status_t due_status[$];

  // --------------------------------------------------------------------------
  // Parser model. It tracks the same things the hardware must track: the
  // running sum, the pending additive sign, the current term, the pending
  // multiplicative operator, the literal under construction, its unary minus,
  // where the parse stands and the first error seen.
  // --------------------------------------------------------------------------
  logic [31:0]        sum_total;
  logic               sum_minus;
  logic [31:0]        term_val;
  iiee_pkg::term_op_t term_pend;
  logic [31:0]        lit_val;
  logic               lit_neg;
  iiee_pkg::phase_t   parse_ph;
  iiee_pkg::status_t  err_st;

  function automatic void clear_parse();
    sum_total = '0;
    sum_minus = 1'b0;
    term_val  = '0;
    term_pend = iiee_pkg::OP_NONE;
    lit_val   = '0;
    lit_neg   = 1'b0;
    parse_ph  = iiee_pkg::PH_FIRST;
    err_st    = iiee_pkg::ST_OK;
  endfunction

  // Signed division truncating toward zero. Working on magnitudes keeps the
  // most negative value divided by -1 well defined: it wraps onto itself.
  function automatic logic [31:0] trunc_quotient(logic [31:0] a, logic [31:0] b);
    logic [31:0] ma, mb, q;
    ma = a[31] ? -a : a;
    mb = b[31] ? -b : b;
    q  = ma / mb;
    return (a[31] != b[31]) ? -q : q;
  endfunction

  function automatic logic [31:0] running_total();
    return sum_minus ? (sum_total - term_val) : (sum_total + term_val);
  endfunction

  // A finished literal joins the current term; a zero divisor latches an error.
  function automatic void fold_literal();
    logic [31:0] v;
    v = lit_neg ? -lit_val : lit_val;
    case (term_pend)
      iiee_pkg::OP_MUL: term_val = term_val * v;
      iiee_pkg::OP_DIV: begin
        if (v == '0) err_st = iiee_pkg::ST_DIV0;
        else term_val = trunc_quotient(term_val, v);
      end
      default: term_val = v;
    endcase
    lit_val   = '0;
    lit_neg   = 1'b0;
    term_pend = iiee_pkg::OP_NONE;
  endfunction

  // Advance the model by one accepted character. An end byte queues the
  // result it must produce and starts a fresh expression.
  function automatic void eval_char(logic [7:0] c);
    iiee_pkg::status_t st;
    logic [31:0]       val;
    logic              digit;
    digit = (c >= iiee_pkg::CH_ZERO) && (c <= iiee_pkg::CH_NINE);

    if (c == iiee_pkg::CH_NUL) begin
      st  = err_st;
      val = '0;
      if (st == iiee_pkg::ST_OK) begin
        if (parse_ph == iiee_pkg::PH_FIRST) begin
          st = iiee_pkg::ST_EMPTY;
        end else if (parse_ph == iiee_pkg::PH_OPERAND || parse_ph == iiee_pkg::PH_NEG) begin
          st = iiee_pkg::ST_SYNTAX;
        end else begin
          if (parse_ph == iiee_pkg::PH_DIGITS) fold_literal();
          if (err_st != iiee_pkg::ST_OK) st = err_st;
          else val = running_total();
        end
      end
      due_values.push_back((st == iiee_pkg::ST_OK) ? val : '0);
      due_status.push_back(st);
      clear_parse();
      return;
    end

    // A latched error or a number after a number silences the rest of the line.
    if (err_st != iiee_pkg::ST_OK || parse_ph == iiee_pkg::PH_IGNORE) return;

    if (parse_ph == iiee_pkg::PH_DIGITS) begin
      if (digit) begin
        lit_val = lit_val * 32'd10 + 32'(c - iiee_pkg::CH_ZERO);
        return;
      end
      fold_literal();
      if (err_st != iiee_pkg::ST_OK) return;
      parse_ph = iiee_pkg::PH_OPER;
    end

    if (c == iiee_pkg::CH_SPACE) return;

    case (parse_ph) inside
      iiee_pkg::PH_FIRST, iiee_pkg::PH_OPERAND, iiee_pkg::PH_NEG: begin
        if (digit) begin
          lit_val  = 32'(c - iiee_pkg::CH_ZERO);
          parse_ph = iiee_pkg::PH_DIGITS;
        end else if (c == iiee_pkg::CH_SUB && parse_ph != iiee_pkg::PH_NEG) begin
          lit_neg  = 1'b1;
          parse_ph = iiee_pkg::PH_NEG;
        end else begin
          err_st = iiee_pkg::ST_SYNTAX;
        end
      end
      default: begin
        if (c == iiee_pkg::CH_MUL || c == iiee_pkg::CH_DIV) begin
          term_pend = (c == iiee_pkg::CH_MUL) ? iiee_pkg::OP_MUL : iiee_pkg::OP_DIV;
          parse_ph  = iiee_pkg::PH_OPERAND;
        end else if (c == iiee_pkg::CH_ADD || c == iiee_pkg::CH_SUB) begin
          sum_total = running_total();
          sum_minus = (c == iiee_pkg::CH_SUB);
          term_val  = '0;
          term_pend = iiee_pkg::OP_NONE;
          parse_ph  = iiee_pkg::PH_OPERAND;
        end else if (digit) begin
          parse_ph = iiee_pkg::PH_IGNORE;
        end else begin
          err_st = iiee_pkg::ST_SYNTAX;
        end
      end
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Receiver: stalls are drawn at each falling edge, and result beats are
  // checked at the rising edge where they are accepted.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    logic [31:0]       want_value;
    iiee_pkg::status_t want_status;
    if (rst_n && out_valid && !out_stall) begin
      if (due_values.size() == 0) begin
        $error("result beat with none expected: out_value %0d, out_status %0d",
               out_value, out_status);
        fail_count++;
      end else begin
        want_value  = due_values.pop_front();
        want_status = due_status.pop_front();
        if (out_value !== want_value) begin
          $error("out_value: expected %0d, got %0d", $signed(want_value), out_value);
          fail_count++;
        end
        if (out_status !== want_status) begin
          $error("out_status: expected %0d, got %0d", want_status, out_status);
          fail_count++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sender. Entered and left at a falling edge. Valid stays high from one beat
  // to the next unless an idle cycle is drawn, and the character is held for
  // as long as the evaluator stalls.
  // --------------------------------------------------------------------------
  task automatic send_char(input logic [7:0] c);
    while ($urandom_range(99) < idle_pct) begin
      in_valid = 1'b0;
      in_ch    = 8'($urandom);
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_ch    = c;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    eval_char(c);
    chars_sent++;
    @(negedge clk);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
    send_char(iiee_pkg::CH_NUL);
  endtask

  // --------------------------------------------------------------------------
  // Directed tests.
  // --------------------------------------------------------------------------
  task automatic test_blank_and_empty();
    send_text("");
    send_text("  ");
  endtask

  task automatic test_precedence();
    send_text("1+2*3-8/4");
    send_text("7 - -3");
  endtask

  // Truncation toward zero, a zero divisor, and the most negative value over -1.
  task automatic test_division();
    send_text("-7/2");
    send_text("5/0");
    send_text("-2147483648/-1");
  endtask

  // Missing operands, a doubled unary minus, a tab, and bytes with the top
  // bit set where an operand is due.
  task automatic test_syntax_errors();
    send_text("1+");
    send_text("*2");
    send_text("--4");
    send_text("3\t");
    send_text("9-\377");
    send_text("\200");
  endtask

  // A number after a finished number ends evaluation; the tail is ignored.
  task automatic test_number_after_number();
    send_text("4 5+\001");
  endtask

  // A literal past 32 bits wraps while its digits accumulate.
  task automatic test_literal_wrap();
    send_text("4294967297*3");
  endtask

  // --------------------------------------------------------------------------
  // Random traffic. Most lines are well formed with random literals, signs,
  // operators and spacing, so that the deeper parse states are reached; some
  // of those get one defect, and the rest are blank lines or random noise.
  // --------------------------------------------------------------------------
  task automatic send_random_expr();
    logic [7:0] line[$];
    int         kind, nterms, ndig;
    kind = $urandom_range(99);
    if (kind < 10) begin
      repeat ($urandom_range(0, 3)) line.push_back(iiee_pkg::CH_SPACE);
    end else if (kind < 25) begin
      repeat ($urandom_range(1, 8)) line.push_back(8'($urandom_range(1, 255)));
    end else begin
      nterms = $urandom_range(1, 6);
      for (int t = 0; t < nterms; t++) begin
        if (t > 0) begin
          if ($urandom_range(1)) line.push_back(iiee_pkg::CH_SPACE);
          case ($urandom_range(3))
            0:       line.push_back(iiee_pkg::CH_ADD);
            1:       line.push_back(iiee_pkg::CH_SUB);
            2:       line.push_back(iiee_pkg::CH_MUL);
            default: line.push_back(iiee_pkg::CH_DIV);
          endcase
          if ($urandom_range(1)) line.push_back(iiee_pkg::CH_SPACE);
        end
        if ($urandom_range(3) == 0) line.push_back(iiee_pkg::CH_SUB);
        // Mostly short literals, so products and quotients stay readable and
        // zero divisors turn up; now and then one long enough to wrap.
        ndig = ($urandom_range(19) == 0) ? $urandom_range(10, 12) : $urandom_range(1, 3);
        repeat (ndig) line.push_back(8'(iiee_pkg::CH_ZERO + $urandom_range(9)));
      end
      repeat ($urandom_range(0, 1)) line.push_back(iiee_pkg::CH_SPACE);
      if ($urandom_range(5) == 0) begin
        case ($urandom_range(3))
          0: line[$urandom_range(line.size() - 1)] = 8'($urandom_range(1, 255));
          1: line.push_back(($urandom_range(1)) ? iiee_pkg::CH_MUL : iiee_pkg::CH_ADD);
          2: begin
            line.push_back(iiee_pkg::CH_SPACE);
            line.push_back(8'(iiee_pkg::CH_ZERO + $urandom_range(9)));
            repeat ($urandom_range(0, 4)) line.push_back(8'($urandom_range(1, 255)));
          end
          default: begin
            line.push_front(iiee_pkg::CH_SUB);
            line.push_front(iiee_pkg::CH_SUB);
          end
        endcase
      end
    end
    foreach (line[i]) send_char(line[i]);
    send_char(iiee_pkg::CH_NUL);
  endtask

  task automatic test_random_traffic(input int idle, input int stall, input int n_chars);
    int start;
    idle_pct  = idle;
    stall_pct = stall;
    start     = chars_sent;
    while (chars_sent - start < n_chars) send_random_expr();
  endtask

  // --------------------------------------------------------------------------
  // Main sequence.
  // --------------------------------------------------------------------------
  initial begin
    clear_parse();
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    test_blank_and_empty();
    test_precedence();
    test_division();
    test_syntax_errors();
    test_number_after_number();
    test_literal_wrap();

    test_random_traffic(0, 0, 350);
    test_random_traffic(64, 0, 350);
    test_random_traffic(0, 64, 350);
    test_random_traffic(30, 30, 350);

    in_valid = 1'b0;
    while (due_values.size() != 0) @(posedge clk);
    // Room for a slow final fold to misbehave and emit a stray beat.
    repeat (40) @(posedge clk);

    if (fail_count == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run of this stimulus.
  initial begin
    #10_000_000;
    $display("tb NOT OK");
    $finish;
  end

endmodule
